### design/imufd_pkg.sv
package imufd_pkg;

	localparam int WIN_LEN = 22;
	localparam logic [7:0] MARK_HEAD = 8'h7B;
	localparam logic [7:0] MARK_TAIL = 8'h7D;

	localparam int HALF_TURN = 11796480;
	localparam int FULL_TURN = 23592960;

	// A full turn is 45 * 2**19 units, so whole turns are bits 19 up divided by 45.
	localparam int TURN_SHIFT = 19;
	localparam int TURN_UNITS = 45;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_UNITS = 23302;

	localparam logic [15:0] GAIN_RESET = 16'd200;

	localparam int ADDR_W = 3;
	localparam logic REG_YAW_GAIN = 1'b0;

	typedef struct packed {
		logic signed [15:0] supply_mv;
		logic signed [15:0] rate_z;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_x;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
	} frame_t;

	// One yaw step reduced to less than a full turn, with the sign of the raw step.
	typedef struct packed {
		logic               neg;
		logic               zero;
		logic signed [25:0] q;
	} yaw_step_t;

endpackage

### design/imufd_yaw_red.sv
module imufd_yaw_red (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [15:0]       rate_z,
	input  logic [15:0]              gain,
	output imufd_pkg::yaw_step_t     step
);
	import imufd_pkg::*;

	logic signed [32:0] p_s2;
	logic signed [32:0] mag;
	logic [11:0]        x;
	logic               neg_s3;
	logic               zero_s3;
	logic [18:0]        m_lo_s3;
	logic [11:0]        x_s3;
	logic [26:0]        kmul_s3;
	logic [6:0]         k;
	logic [11:0]        d;
	logic [24:0]        rem;
	yaw_step_t          step_s4;

	assign mag = p_s2[32] ? -p_s2 : p_s2;
	assign x   = mag[30:TURN_SHIFT];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2    <= rate_z * $signed({1'b0, gain});
			neg_s3  <= p_s2[32];
			zero_s3 <= (p_s2 == '0);
			m_lo_s3 <= mag[TURN_SHIFT-1:0];
			x_s3    <= x;
			kmul_s3 <= 27'(x) * 27'(RECIP_UNITS);
			step_s4 <= '{neg: neg_s3, zero: zero_s3, q: neg_s3 ? -$signed({1'b0, rem})
				: $signed({1'b0, rem})};
		end
	end

	// Whole turns by reciprocal; exact for every 12-bit turn index
	assign k   = kmul_s3[26:RECIP_SHIFT];
	assign d   = x_s3 - 12'(k) * 12'(TURN_UNITS);
	assign rem = {d[5:0], m_lo_s3};

	assign step = step_s4;

endmodule

### design/imu_frame_decoder.sv
// Byte-stream frame decoder for an inertial sensor. One received byte is taken per
// word on the slave side, one per clock when the master side keeps up; s_tready drops
// only while a decoded frame sits in the output register untaken. A frame (0x7B at the
// oldest of the last 22 bytes, 0x7D at the newest) goes through stages s1 to s4 and
// the output register to the master side. The yaw accumulator updates per frame from
// a step that a three-stage multiply and turn-reduction pipeline prepares ahead of it,
// so back-to-back overlapping frames sustain one per cycle while the master side keeps
// up. yaw_step_gain (address 0) must be written only while no frame is in flight.
module imu_frame_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] rate_x,
	// [79:64] rate_y, [95:80] rate_z, [111:96] supply_mv, [136:112] yaw_angle
	output logic [143:0]                    m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [imufd_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import imufd_pkg::*;

	localparam logic signed [26:0] HALF27 = 27'(HALF_TURN);
	localparam logic signed [26:0] FULL27 = 27'(FULL_TURN);

	logic [15:0]        gain_q;
	logic [7:0]         win_q [1:WIN_LEN-1];
	logic [4:0]         fill_q;
	logic               en;
	logic               accept;
	logic               hit;
	frame_t             fr_in;
	frame_t             fr_s1, fr_s2, fr_s3, fr_s4;
	logic               v_s1, v_s2, v_s3, v_s4;
	yaw_step_t          step_s4;
	logic signed [24:0] yaw_q;
	logic signed [26:0] r;
	logic signed [24:0] yaw_nx;
	frame_t             out_fr_q;
	logic signed [24:0] out_yaw_q;
	logic               out_v_q;

	// Configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_YAW_GAIN) ? {16'd0, gain_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_YAW_GAIN) begin
			gain_q <= pwdata[15:0];
		end
	end

	// Whole pipeline advances together; stall only on a held result
	assign en       = !out_v_q || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	// Fields of the window after this word shifts in
	always_comb begin
		fr_in.accel_x   = {win_q[2], win_q[3]};
		fr_in.accel_y   = {win_q[4], win_q[5]};
		fr_in.accel_z   = {win_q[6], win_q[7]};
		fr_in.rate_x    = {win_q[8], win_q[9]};
		fr_in.rate_y    = {win_q[10], win_q[11]};
		fr_in.rate_z    = {win_q[12], win_q[13]};
		fr_in.supply_mv = {win_q[20], win_q[21]};
	end

	assign hit = (fill_q >= 5'(WIN_LEN - 1)) && (win_q[1] == MARK_HEAD)
		&& (s_tdata == MARK_TAIL);

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 1; i < WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_LEN-1] <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept && fill_q != 5'(WIN_LEN)) begin
			fill_q <= fill_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid && hit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s1 <= fr_in;
			fr_s2 <= fr_s1;
			fr_s3 <= fr_s2;
			fr_s4 <= fr_s3;
		end
	end

	imufd_yaw_red u_yaw_red (
		.clk    (clk),
		.en     (en),
		.rate_z (fr_s1.rate_z),
		.gain   (gain_q),
		.step   (step_s4)
	);

	// One fold back into range; an exact half turn keeps the side of the raw step
	assign r = 27'(yaw_q) + 27'(step_s4.q);

	always_comb begin
		yaw_nx = 25'(r);
		if (step_s4.zero) begin
			yaw_nx = yaw_q;
		end else if (!step_s4.neg) begin
			if (r > HALF27) begin
				yaw_nx = 25'(r - FULL27);
			end else if (r == -HALF27) begin
				yaw_nx = 25'(HALF27);
			end
		end else begin
			if (r < -HALF27) begin
				yaw_nx = 25'(r + FULL27);
			end else if (r == HALF27) begin
				yaw_nx = 25'(-HALF27);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s4;
			if (v_s4) begin
				yaw_q <= yaw_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s4) begin
			out_fr_q  <= fr_s4;
			out_yaw_q <= yaw_nx;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, out_yaw_q, out_fr_q};

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(27'(yaw_q) >= -HALF27) && (27'(yaw_q) <= HALF27))
		else $error("yaw accumulator out of range");

	a_out_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_yaw_q == yaw_q))
		else $error("output yaw differs from accumulator");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (fill_q == 5'(WIN_LEN)))
		else $error("frame detected before window filled");

endmodule
